/* src/grid_distance_field_update_defines.svh */
// assertion macros used by the checker file
`ifndef GRID_DISTANCE_FIELD_UPDATE_DEFINES_SVH
`define GRID_DISTANCE_FIELD_UPDATE_DEFINES_SVH

// same-cycle implication, reset masked
`define GDF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define GDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/gdf_pkg.sv */
// shared constants, codes and control types of the grid distance field
`timescale 1ns / 1ps
package gdf_pkg;

    localparam int GRID_DIM  = 64;
    localparam int CELL_SIZE = 4;

    localparam int VAL_W  = 12;
    localparam int DIM_W  = 7;
    localparam int COORD_W = 11;

    localparam logic [VAL_W-1:0] FAR_VALUE   = 12'd4080;
    localparam logic [VAL_W-1:0] REMOVE_STEP = 12'd32;
    localparam logic [VAL_W-1:0] VALUE_MAX   = 12'd4095;
    localparam logic [DIM_W-1:0] DIM_RESET   = 7'd64;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic CFG_ACROSS = 1'b0;
    localparam logic CFG_DOWN   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_WALK,
        ST_DRAIN,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic scan_init;
        logic scan_step;
        logic rd_item;
        logic rd_done;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic is_walk;
        logic is_read;
        logic scan_last;
        logic pipe_empty;
        logic out_free;
    } t_status;

endpackage

/* src/grid_distance_field_update.sv */
// top level of the grid distance field: controller plus datapath
//
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_operation, i_x_coord, i_y_coord, i_thin_mode
// out       output     o_out_valid / i_out_ready   o_distance
// cfg       input      i_cfg_we                    i_cfg_index, i_cfg_data
//
// query and remove read at most one store entry; an applied add walks all width*height cells,
// then drains the walk pipeline (the square-root depth grows with GRID_DIM); it walks
// one grid cell per cycle through the square-root pipeline and the single store port.
// after reset a clearing pass writes every store entry, and no beat is taken during it.
// one item at a time; a finished beat waits in the output register while the next item is taken.
`timescale 1ns / 1ps
module grid_distance_field_update #(
    parameter int GridDim  = gdf_pkg::GRID_DIM,
    parameter int CellSize = gdf_pkg::CELL_SIZE
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [gdf_pkg::DIM_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_operation,
    input  logic signed [gdf_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [gdf_pkg::COORD_W-1:0] i_y_coord,
    input  logic                               i_thin_mode,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [gdf_pkg::VAL_W-1:0]          o_distance
);

    gdf_pkg::t_cmd    cmd;
    gdf_pkg::t_status status;

    // control
    gdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    // data
    gdf_datapath #(
        .GridDim  (GridDim),
        .CellSize (CellSize)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_operation (i_operation),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .i_thin_mode (i_thin_mode),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_distance  (o_distance)
    );

endmodule

/* src/gdf_ctrl.sv */
// controller state machine: clear pass, dispatch, grid walk and response
`timescale 1ns / 1ps
module gdf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  gdf_pkg::t_status  i_status,
    output gdf_pkg::t_cmd     o_cmd,
    output logic              o_in_ready
);

    gdf_pkg::t_state r_state;
    gdf_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gdf_pkg::ST_CLEAR: begin
                if (i_status.clear_last) n_state = gdf_pkg::ST_IDLE;
            end
            gdf_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = gdf_pkg::ST_DISPATCH;
            end
            gdf_pkg::ST_DISPATCH: begin
                if (i_status.is_walk) begin
                    n_state = gdf_pkg::ST_WALK;
                end else if (i_status.is_read) begin
                    n_state = gdf_pkg::ST_READ;
                end else begin
                    n_state = gdf_pkg::ST_RESP;
                end
            end
            gdf_pkg::ST_READ: begin
                n_state = gdf_pkg::ST_RESP;
            end
            gdf_pkg::ST_WALK: begin
                if (i_status.scan_last) n_state = gdf_pkg::ST_DRAIN;
            end
            gdf_pkg::ST_DRAIN: begin
                if (i_status.pipe_empty) n_state = gdf_pkg::ST_RESP;
            end
            gdf_pkg::ST_RESP: begin
                if (i_status.out_free) n_state = gdf_pkg::ST_IDLE;
            end
            default: n_state = gdf_pkg::ST_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            gdf_pkg::ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            gdf_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            gdf_pkg::ST_DISPATCH: begin
                o_cmd.scan_init = 1'b1;
                o_cmd.rd_item   = 1'b1;
            end
            gdf_pkg::ST_READ: begin
                o_cmd.rd_done = 1'b1;
            end
            gdf_pkg::ST_WALK: begin
                o_cmd.scan_step = 1'b1;
            end
            gdf_pkg::ST_DRAIN: begin
                o_cmd = '0;
            end
            gdf_pkg::ST_RESP: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* src/gdf_sqrt.sv */
// pipelined integer square root, one root bit per stage, with a tag
`timescale 1ns / 1ps
module gdf_sqrt #(
    parameter int RadW = 22,
    parameter int TagW = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [RadW-1:0]      i_rad,
    input  logic [TagW-1:0]      i_tag,
    output logic                 o_valid,
    output logic [RadW/2-1:0]    o_root,
    output logic [TagW-1:0]      o_tag,
    output logic                 o_busy
);

    localparam int RootW = RadW / 2;
    localparam int RemW  = RootW + 4;

    logic [RootW-1:0] r_vld;
    logic [RemW-1:0]  r_rem  [RootW];
    logic [RootW-1:0] r_root [RootW];
    logic [RadW-1:0]  r_rad  [RootW];
    logic [TagW-1:0]  r_tag  [RootW];

    logic [RemW-1:0]  s_rem   [RootW];
    logic [RootW-1:0] s_root  [RootW];
    logic [RadW-1:0]  s_rad   [RootW];
    logic [RemW-1:0]  s_cur   [RootW];
    logic [RemW-1:0]  s_trial [RootW];
    logic [RemW-1:0]  n_rem   [RootW];
    logic [RootW-1:0] n_root  [RootW];
    logic [RadW-1:0]  n_rad   [RootW];

    // stage inputs
    always_comb begin
        s_rem[0]  = '0;
        s_root[0] = '0;
        s_rad[0]  = i_rad;
        for (int s = 1; s < RootW; s++) begin
            s_rem[s]  = r_rem[s-1];
            s_root[s] = r_root[s-1];
            s_rad[s]  = r_rad[s-1];
        end
    end

    // one trial subtract per stage
    always_comb begin
        for (int s = 0; s < RootW; s++) begin
            s_cur[s]   = {s_rem[s][RemW-3:0], s_rad[s][RadW-1 -: 2]};
            s_trial[s] = RemW'({s_root[s], 2'b01});
            n_rad[s]   = {s_rad[s][RadW-3:0], 2'b00};
            if (s_cur[s] >= s_trial[s]) begin
                n_rem[s]  = s_cur[s] - s_trial[s];
                n_root[s] = {s_root[s][RootW-2:0], 1'b1};
            end else begin
                n_rem[s]  = s_cur[s];
                n_root[s] = {s_root[s][RootW-2:0], 1'b0};
            end
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[RootW-2:0], i_valid};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        for (int s = 0; s < RootW; s++) begin
            r_rem[s]  <= n_rem[s];
            r_root[s] <= n_root[s];
            r_rad[s]  <= n_rad[s];
        end
        for (int s = 1; s < RootW; s++) begin
            r_tag[s] <= r_tag[s-1];
        end
    end

    assign o_valid = r_vld[RootW-1];
    assign o_root  = r_root[RootW-1];
    assign o_tag   = r_tag[RootW-1];
    assign o_busy  = |r_vld;

endmodule

/* src/gdf_datapath.sv */
// datapath: config registers, cell mapping, distance store, walk pipeline, output register
`timescale 1ns / 1ps
module gdf_datapath #(
    parameter int GridDim  = gdf_pkg::GRID_DIM,
    parameter int CellSize = gdf_pkg::CELL_SIZE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [gdf_pkg::DIM_W-1:0]   i_cfg_data,
    input  logic [1:0]                  i_operation,
    input  logic signed [gdf_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [gdf_pkg::COORD_W-1:0] i_y_coord,
    input  logic                        i_thin_mode,
    input  logic                        i_out_ready,
    input  gdf_pkg::t_cmd               i_cmd,
    output gdf_pkg::t_status            o_status,
    output logic                        o_out_valid,
    output logic [gdf_pkg::VAL_W-1:0]   o_distance
);

    localparam int CW    = $clog2(GridDim);
    localparam int DW    = $clog2(GridDim + 1);
    localparam int Depth = GridDim * GridDim;
    localparam int AW    = $clog2(Depth);
    localparam int Shift = 16;
    localparam int Recip = (2 ** Shift + CellSize - 1) / CellSize;
    localparam int MagW  = gdf_pkg::COORD_W + 1;
    localparam int PrW   = MagW + Shift + 1;
    localparam int QW    = gdf_pkg::COORD_W;
    localparam int RadW  = 2 * CW + 10;
    localparam int RootW = RadW / 2;
    localparam int VW    = gdf_pkg::VAL_W;

    // configuration
    logic [gdf_pkg::DIM_W-1:0] r_cells_across;
    logic [gdf_pkg::DIM_W-1:0] r_cells_down;
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_across <= gdf_pkg::DIM_RESET;
            r_cells_down   <= gdf_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == gdf_pkg::CFG_ACROSS) r_cells_across <= i_cfg_data;
            if (i_cfg_index == gdf_pkg::CFG_DOWN)   r_cells_down   <= i_cfg_data;
        end
    end

    assign w_eff = (32'(r_cells_across) > GridDim) ? DW'(GridDim) : DW'(r_cells_across);
    assign h_eff = (32'(r_cells_down) > GridDim) ? DW'(GridDim) : DW'(r_cells_down);

    // coordinate to cell: magnitude times reciprocal, truncating toward zero
    logic            neg_x, neg_y;
    logic [MagW-1:0] mag_x, mag_y;
    logic [PrW-1:0]  prod_x, prod_y;
    logic [QW-1:0]   q_x, q_y;
    logic            in_x, in_y;

    always_comb begin
        neg_x  = i_x_coord[gdf_pkg::COORD_W-1];
        neg_y  = i_y_coord[gdf_pkg::COORD_W-1];
        mag_x  = neg_x ? MagW'(-MagW'(i_x_coord)) : MagW'(i_x_coord);
        mag_y  = neg_y ? MagW'(-MagW'(i_y_coord)) : MagW'(i_y_coord);
        prod_x = PrW'(mag_x) * PrW'(Recip);
        prod_y = PrW'(mag_y) * PrW'(Recip);
        q_x    = prod_x[Shift +: QW];
        q_y    = prod_y[Shift +: QW];
        in_x   = (!neg_x || (q_x == '0)) && (32'(q_x) < 32'(w_eff));
        in_y   = (!neg_y || (q_y == '0)) && (32'(q_y) < 32'(h_eff));
    end

    // captured item and thin counter
    logic [1:0]    r_op;
    logic [CW-1:0] r_cx, r_cy;
    logic          r_inside;
    logic          r_apply;
    logic [1:0]    r_thin_phase;
    logic [VW-1:0] r_result;
    logic [AW-1:0] item_addr;
    logic [VW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thin_phase <= '0;
        end else if (i_cmd.capture && (i_operation == gdf_pkg::OP_ADD) && i_thin_mode) begin
            r_thin_phase <= (r_thin_phase == 2'd2) ? 2'd0 : r_thin_phase + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_operation;
            r_cx     <= CW'(q_x);
            r_cy     <= CW'(q_y);
            r_inside <= in_x && in_y;
            r_apply  <= !i_thin_mode || (r_thin_phase == 2'd0);
            r_result <= (i_operation == gdf_pkg::OP_QUERY) ? gdf_pkg::FAR_VALUE : '0;
        end else if (i_cmd.rd_done && (r_op == gdf_pkg::OP_QUERY)) begin
            r_result <= r_rd_data;
        end
    end

    assign item_addr = AW'(32'(r_cy) * GridDim + 32'(r_cx));

    // clear sweep counter
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // scan counters over the grid
    logic [CW-1:0] r_a, r_b;
    logic [AW-1:0] r_row_base;
    logic          row_end;
    logic          scan_last;

    assign row_end   = (r_a == CW'(w_eff - 1'b1));
    assign scan_last = row_end && (r_b == CW'(h_eff - 1'b1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_a        <= '0;
            r_b        <= '0;
            r_row_base <= '0;
        end else if (i_cmd.scan_step) begin
            if (row_end) begin
                r_a        <= '0;
                r_b        <= r_b + 1'b1;
                r_row_base <= r_row_base + AW'(GridDim);
            end else begin
                r_a <= r_a + 1'b1;
            end
        end
    end

    // walk pipeline: differences, squares, square root, compare
    logic            r_p1_v, r_p2_v, r_p4_v;
    logic [CW-1:0]   r_p1_dx, r_p1_dy;
    logic [AW-1:0]   r_p1_addr, r_p2_addr, r_p4_addr;
    logic [2*CW-1:0] r_p2_sqx, r_p2_sqy;
    logic [VW-1:0]   r_p4_d;
    logic [RadW-1:0] rad;
    logic            sq_v, sq_busy;
    logic [RootW-1:0] sq_root;
    logic [AW-1:0]   sq_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else begin
            r_p1_v <= i_cmd.scan_step;
            r_p2_v <= r_p1_v;
            r_p4_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_dx   <= (r_a > r_cx) ? r_a - r_cx : r_cx - r_a;
        r_p1_dy   <= (r_b > r_cy) ? r_b - r_cy : r_cy - r_b;
        r_p1_addr <= r_row_base + AW'(r_a);
        r_p2_sqx  <= (2*CW)'(r_p1_dx) * (2*CW)'(r_p1_dx);
        r_p2_sqy  <= (2*CW)'(r_p1_dy) * (2*CW)'(r_p1_dy);
        r_p2_addr <= r_p1_addr;
        r_p4_d    <= (32'(sq_root) > 32'(gdf_pkg::VALUE_MAX)) ? gdf_pkg::VALUE_MAX
                                                                 : VW'(sq_root);
        r_p4_addr <= sq_tag;
    end

    assign rad = RadW'({(2*CW+1)'(r_p2_sqx) + (2*CW+1)'(r_p2_sqy), 8'b0});

    gdf_sqrt #(
        .RadW (RadW),
        .TagW (AW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p2_v),
        .i_rad   (rad),
        .i_tag   (r_p2_addr),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_tag   (sq_tag),
        .o_busy  (sq_busy)
    );

    // distance store
    logic [VW-1:0] mem [Depth];
    logic [AW-1:0] rd_addr;
    logic [VW:0]   raised;

    assign rd_addr = i_cmd.rd_item ? item_addr : sq_tag;
    assign raised  = (VW+1)'(r_rd_data) + (VW+1)'(gdf_pkg::REMOVE_STEP);

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
        if (i_cmd.clear_step) begin
            mem[r_clr_addr] <= gdf_pkg::FAR_VALUE;
        end else if (r_p4_v && (r_p4_d < r_rd_data)) begin
            mem[r_p4_addr] <= r_p4_d;
        end else if (i_cmd.rd_done && (r_op == gdf_pkg::OP_REMOVE)) begin
            mem[item_addr] <= raised[VW] ? gdf_pkg::VALUE_MAX : raised[VW-1:0];
        end
    end

    // output register
    logic          r_out_valid;
    logic [VW-1:0] r_out_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_out_dist <= r_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_out_dist;

    // status
    always_comb begin
        o_status.clear_last = (r_clr_addr == AW'(Depth - 1));
        o_status.is_walk    = (r_op == gdf_pkg::OP_ADD) && r_apply && r_inside;
        o_status.is_read    = ((r_op == gdf_pkg::OP_QUERY) || (r_op == gdf_pkg::OP_REMOVE))
                              && r_inside;
        o_status.scan_last  = scan_last;
        o_status.pipe_empty = !r_p1_v && !r_p2_v && !sq_busy && !r_p4_v;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

endmodule

/* src/gdf_checker.sv */
// port-level checks of the grid distance field, bound to the top level
`timescale 1ns / 1ps
`include "grid_distance_field_update_defines.svh"
module gdf_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cfg_we,
    input logic                               i_cfg_index,
    input logic [gdf_pkg::DIM_W-1:0]          i_cfg_data,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic [1:0]                         i_operation,
    input logic signed [gdf_pkg::COORD_W-1:0] i_x_coord,
    input logic signed [gdf_pkg::COORD_W-1:0] i_y_coord,
    input logic                               i_thin_mode,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [gdf_pkg::VAL_W-1:0]          o_distance
);

    // a pending output beat holds until taken
    `GDF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_distance), "output beat dropped or changed while stalled")

    // reset starts the clearing pass, so no input beat right after it
    `GDF_ASSERT_NEXT(a_clear_after_reset, i_clk, 1'b1, !i_rst_n, !o_in_ready, "input taken during store clear")

    // an accepted item is worked before the next one is taken
    `GDF_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second item taken while one is in work")

endmodule

bind grid_distance_field_update gdf_checker u_gdf_checker (.*);

/* dv/tb_top.sv */
// self-checking testbench for the grid distance field update block
`timescale 1ns / 1ps

// tracks the distance grid and holds the distances still owed by the block
class distance_tracker;
    logic [11:0] grid [gdf_pkg::GRID_DIM*gdf_pkg::GRID_DIM];
    int unsigned across;
    int unsigned down;
    int unsigned thin_count;
    logic [11:0] owed [$];
    int errors;

    function new();
        foreach (grid[i]) grid[i] = gdf_pkg::FAR_VALUE;
        across = 64;
        down = 64;
        thin_count = 0;
        errors = 0;
    endfunction

    function void set_reg(logic idx, int unsigned val);
        if (idx == gdf_pkg::CFG_ACROSS) across = val;
        else down = val;
    endfunction

    // bitwise integer square root
    function int unsigned int_sqrt(int unsigned v);
        int unsigned res;
        int unsigned bitv;
        res = 0;
        bitv = 1 << 30;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // map coordinate to cell, truncating toward zero
    function bit cell_of(logic signed [10:0] c, int unsigned dim, output int unsigned cell_idx);
        int q;
        q = int'(c) / gdf_pkg::CELL_SIZE;
        cell_idx = q;
        return (q >= 0) && (q < int'(dim));
    endfunction

    // apply one accepted input beat and note the distance it owes
    function void note_item(logic [1:0] op, logic signed [10:0] x, logic signed [10:0] y,
                            logic thin);
        int unsigned w, h, cx, cy, dx, dy, d, idx;
        bit in_grid, apply;
        logic [11:0] res;
        w = (across > 64) ? 64 : across;
        h = (down > 64) ? 64 : down;
        in_grid = cell_of(x, w, cx);
        in_grid = cell_of(y, h, cy) && in_grid;
        res = '0;
        if (op == gdf_pkg::OP_QUERY) begin
            res = in_grid ? grid[cx + cy*64] : gdf_pkg::FAR_VALUE;
        end else if (op == gdf_pkg::OP_ADD) begin
            apply = 1;
            if (thin) begin
                apply = (thin_count == 0);
                thin_count = (thin_count + 1) % 3;
            end
            if (apply && in_grid) begin
                for (int b = 0; b < h; b++) begin
                    for (int a = 0; a < w; a++) begin
                        dx = (a > cx) ? a - cx : cx - a;
                        dy = (b > cy) ? b - cy : cy - b;
                        d = int_sqrt((dx*dx + dy*dy) * 256);
                        if (d > 4095) d = 4095;
                        idx = a + b*64;
                        if (d < grid[idx]) grid[idx] = d[11:0];
                    end
                end
            end
        end else if (op == gdf_pkg::OP_REMOVE) begin
            if (in_grid) begin
                idx = cx + cy*64;
                d = grid[idx] + 32;
                grid[idx] = (d > 4095) ? 12'd4095 : d[11:0];
            end
        end
        owed.push_back(res);
    endfunction

    // compare one output beat with the oldest owed distance
    function void check_beat(logic [11:0] got);
        logic [11:0] want;
        if (owed.size() == 0) begin
            $error("distance: unexpected beat, actual %0d", got);
            errors++;
            return;
        end
        want = owed.pop_front();
        if (got !== want) begin
            $error("distance: expected %0d, actual %0d", want, got);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic i_cfg_index = 0;
    logic [gdf_pkg::DIM_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 0;
    logic o_in_ready;
    logic [1:0] i_operation = '0;
    logic signed [gdf_pkg::COORD_W-1:0] i_x_coord = '0;
    logic signed [gdf_pkg::COORD_W-1:0] i_y_coord = '0;
    logic i_thin_mode = 0;
    logic o_out_valid;
    logic i_out_ready = 0;
    logic [gdf_pkg::VAL_W-1:0] o_distance;

    distance_tracker tracker = new();
    int send_idle = 0;
    int recv_idle = 0;
    int hold_cycles = 0;

    grid_distance_field_update DUT (.*);

    always #6 i_clk = ~i_clk;

    // output beat checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_beat(o_distance);
    end

    // receiver ready, with random idling and long hold-offs
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // run limit
    initial begin
        #60ms;
        $display("FAILURE");
        $finish;
    end

    // offer one input beat, leaving valid high at the falling edge after acceptance
    task automatic send_item(logic [1:0] op, logic signed [10:0] x, logic signed [10:0] y,
                             logic thin);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_operation <= op;
        i_x_coord <= x;
        i_y_coord <= y;
        i_thin_mode <= thin;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_item(op, x, y, thin);
        @(negedge i_clk);
    endtask

    // wait until every owed beat has come and the block has settled
    task automatic drain();
        i_in_valid <= 0;
        @(negedge i_clk);
        while (tracker.owed.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val[gdf_pkg::DIM_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 0;
        tracker.set_reg(idx, val);
    endtask

    // random beat, coordinates mostly near the grid
    task automatic random_item(int add_pct);
        int r;
        logic [1:0] op;
        logic signed [10:0] x, y;
        r = $urandom_range(99);
        if (r < 40) op = gdf_pkg::OP_QUERY;
        else if (r < 40 + add_pct) op = gdf_pkg::OP_ADD;
        else if (r < 95) op = gdf_pkg::OP_REMOVE;
        else op = OP_UNUSED;
        if ($urandom_range(99) < 85) begin
            x = 11'($urandom_range(0, tracker.across*4 + 7)) - 11'sd4;
            y = 11'($urandom_range(0, tracker.down*4 + 7)) - 11'sd4;
        end else begin
            x = 11'($urandom);
            y = 11'($urandom);
        end
        send_item(op, x, y, 1'($urandom));
    endtask

    task automatic run_phase(int unsigned w, int unsigned h, int n, int add_pct);
        write_reg(gdf_pkg::CFG_ACROSS, w);
        write_reg(gdf_pkg::CFG_DOWN, h);
        for (int i = 0; i < n; i++) random_item(add_pct);
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, every operation, special cases at reset size
        send_item(gdf_pkg::OP_QUERY, 11'sd0, 11'sd0, 0);
        send_item(gdf_pkg::OP_QUERY, 11'sd255, 11'sd255, 0);
        send_item(gdf_pkg::OP_QUERY, 11'sd256, 11'sd0, 0);
        send_item(gdf_pkg::OP_QUERY, -11'sd1024, 11'sd1023, 1);
        send_item(gdf_pkg::OP_REMOVE, 11'sd8, 11'sd8, 0);
        send_item(gdf_pkg::OP_QUERY, 11'sd8, 11'sd8, 0);
        send_item(gdf_pkg::OP_ADD, 11'sd40, 11'sd60, 0);
        send_item(gdf_pkg::OP_QUERY, 11'sd40, 11'sd60, 0);
        send_item(gdf_pkg::OP_QUERY, 11'sd255, 11'sd0, 0);
        send_item(gdf_pkg::OP_REMOVE, 11'sd40, 11'sd60, 0);
        send_item(gdf_pkg::OP_QUERY, 11'sd40, 11'sd60, 0);
        send_item(gdf_pkg::OP_ADD, -11'sd3, -11'sd2, 1);
        send_item(gdf_pkg::OP_ADD, 11'sd0, 11'sd0, 1);
        send_item(gdf_pkg::OP_ADD, 11'sd100, 11'sd4, 1);
        send_item(gdf_pkg::OP_ADD, 11'sd1023, 11'sd0, 1);
        send_item(gdf_pkg::OP_QUERY, -11'sd3, -11'sd3, 0);
        send_item(gdf_pkg::OP_ADD, -11'sd5, 11'sd0, 0);
        send_item(gdf_pkg::OP_REMOVE, 11'sd1023, -11'sd1024, 0);
        send_item(OP_UNUSED, 11'sd4, 11'sd4, 1);
        send_item(gdf_pkg::OP_QUERY, 11'sd100, 11'sd4, 0);
        drain();

        // receiver idles more than sender
        send_idle = 35;
        recv_idle = 65;
        run_phase(8, 6, 15, 25);
        run_phase(127, 3, 10, 25);
        // sender idles more than receiver
        send_idle = 65;
        recv_idle = 35;
        run_phase(1, 64, 20, 25);
        run_phase(0, 5, 10, 25);
        run_phase(5, 0, 5, 25);

        // no idling, small grid, long receiver hold-off then a sender pause, then the full grid
        send_idle = 0;
        recv_idle = 0;
        write_reg(gdf_pkg::CFG_ACROSS, 4);
        write_reg(gdf_pkg::CFG_DOWN, 4);
        hold_cycles = 400;
        for (int i = 0; i < 20; i++) random_item(10);
        i_in_valid <= 0;
        @(negedge i_clk);
        while (tracker.owed.size() != 0) @(negedge i_clk);
        for (int i = 0; i < 10; i++) random_item(10);
        drain();
        run_phase(64, 64, 30, 4);

        repeat (50) @(posedge i_clk);
        if (tracker.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+src
src/gdf_pkg.sv
src/gdf_ctrl.sv
src/gdf_sqrt.sv
src/gdf_datapath.sv
src/grid_distance_field_update.sv
src/gdf_checker.sv
dv/tb_top.sv
